@@ hw/rtl/pav_pkg.sv @@
// pav_pkg: shared constants, types and the altitude node table for the
// pressure averaging altimeter; depends on nothing

package pav_pkg;

  localparam int WINDOW         = 16;
  localparam int PTR_W          = $clog2(WINDOW);
  localparam int CNT_W          = $clog2(WINDOW + 1);
  localparam int SAMPLE_W       = 24;
  localparam int SUM_W          = SAMPLE_W + PTR_W;
  localparam int ITER_W         = $clog2(SUM_W + 1);
  localparam int SEG_BITS       = 6;
  localparam int TABLE_SEGMENTS = 1 << SEG_BITS;
  localparam int SPAN_LOG2      = 23;
  localparam int SEG_SHIFT      = SPAN_LOG2 - SEG_BITS;
  localparam int ALT_W          = 20;
  localparam int DIFF_W         = ALT_W + 1;
  localparam int PROD_W         = DIFF_W + SEG_SHIFT + 1;
  localparam int ALT_ZERO_P     = 443300;
  localparam longint SEA_LEVEL_LSB = 4150272;
  localparam longint Q30_ONE    = 64'sd1 << 30;

  typedef logic signed [ALT_W-1:0] alt_table_t [0:TABLE_SEGMENTS];

  // one transaction handed from the front part to the back part
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic signed [SUM_W-1:0]    sum;
    logic [CNT_W-1:0]           count;
    logic                       wrapped;
  } pav_item_t;

  // truncating q30 base-2 logarithm, evaluated at elaboration only
  function automatic longint log2_q30(logic [63:0] v, int fb);
    int n;
    logic [63:0] m;
    longint r;
    n = 63;
    if (v == 64'd0) begin
      return -64 * Q30_ONE;
    end
    while (v[n] == 1'b0) n--;
    if (n >= 30) m = v >> (n - 30);
    else m = v << (30 - n);
    r = longint'(n - fb) * Q30_ONE;
    for (int k = 0; k < 30; k++) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        r = r + (64'sd1 << (29 - k));
      end
    end
    return r;
  endfunction

  function automatic longint formula_dm(logic [63:0] p);
    longint l, t, d;
    logic [63:0] lo, hi, mid, prod;
    l  = log2_q30(p, 0) - log2_q30(SEA_LEVEL_LSB, 0);
    t  = (l * 1903) / 10000;
    lo = 64'd1;
    hi = 64'd1 << 31;
    while (hi - lo > 64'd1) begin
      mid = lo + ((hi - lo) >> 1);
      if (log2_q30(mid, 30) <= t) lo = mid;
      else hi = mid;
    end
    d = Q30_ONE - longint'(lo);
    if (d >= 0) begin
      prod = (64'(ALT_ZERO_P) * 64'(d) + (64'd1 << 29)) >> 30;
      return longint'(prod);
    end
    prod = (64'(ALT_ZERO_P) * 64'(-d) + (64'd1 << 29)) >> 30;
    return -longint'(prod);
  endfunction

  function automatic alt_table_t build_table();
    alt_table_t tab;
    longint v;
    tab[0] = ALT_W'(ALT_ZERO_P);
    for (int i = 1; i <= TABLE_SEGMENTS; i++) begin
      v = formula_dm(64'(i) << SEG_SHIFT);
      tab[i] = v[ALT_W-1:0];
    end
    return tab;
  endfunction

  localparam alt_table_t ALT_TABLE = build_table();

endpackage

@@ hw/rtl/pav_front.sv @@
// pav_front: sample ring, running sum and fill tracking
// depends on pav_pkg

module pav_front import pav_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic [SAMPLE_W-1:0] raw_sample,
  output pav_item_t           item
);

  logic signed [SAMPLE_W-1:0] ring [WINDOW];
  logic [WINDOW-1:0]          ring_valid;
  logic [PTR_W-1:0]           ptr;
  logic signed [SUM_W-1:0]    sum;
  logic                       wrapped;

  logic signed [SAMPLE_W-1:0] old_sample;
  logic [PTR_W-1:0]           ptr_next;
  logic                       wrapped_next;

  always_comb begin
    old_sample   = ring_valid[ptr] ? ring[ptr] : '0;
    ptr_next     = (ptr == PTR_W'(WINDOW - 1)) ? '0 : ptr + 1'b1;
    wrapped_next = wrapped | (ptr_next == '0);
    item.sample  = $signed(raw_sample);
    item.sum     = sum - SUM_W'(old_sample) + SUM_W'(item.sample);
    item.wrapped = wrapped_next;
    if (wrapped_next) item.count = CNT_W'(WINDOW);
    else item.count = CNT_W'(ptr_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_valid <= '0;
      ptr        <= '0;
      sum        <= '0;
      wrapped    <= 1'b0;
    end else if (take) begin
      ring_valid[ptr] <= 1'b1;
      ptr             <= ptr_next;
      sum             <= item.sum;
      wrapped         <= wrapped_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) ring[ptr] <= item.sample;
  end

endmodule

@@ hw/rtl/pav_queue.sv @@
// pav_queue: two-entry queue between front and back parts
// depends on pav_pkg

module pav_queue import pav_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      wr,
  input  pav_item_t wr_item,
  output logic      full,
  input  logic      rd,
  output pav_item_t rd_item,
  output logic      empty
);

  pav_item_t  slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] fill;

  assign full    = (fill == 2'd2);
  assign empty   = (fill == 2'd0);
  assign rd_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= '0;
    end else begin
      if (wr) wr_ptr <= ~wr_ptr;
      if (rd) rd_ptr <= ~rd_ptr;
      if (wr && !rd) fill <= fill + 1'b1;
      else if (rd && !wr) fill <= fill - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) slots[wr_ptr] <= wr_item;
  end

endmodule

@@ hw/rtl/pav_back.sv @@
// pav_back: serial divider, table interpolation and result register
// depends on pav_pkg

module pav_back import pav_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_empty,
  input  pav_item_t                  q_item,
  output logic                       q_rd,
  output logic signed [SAMPLE_W-1:0] signed_pressure,
  output logic signed [SAMPLE_W-1:0] averaged_pressure,
  output logic signed [ALT_W-1:0]    altitude_dm,
  output logic                       window_full,
  output logic                       empty,
  input  logic                       pop
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_LOOK = 5'b00100,
    S_MUL  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t                     state;
  pav_item_t                  cur;
  logic [SUM_W-1:0]           quo;
  logic [CNT_W:0]             rem;
  logic [ITER_W-1:0]          iter;
  logic signed [SAMPLE_W-1:0] avg;
  logic signed [DIFF_W-1:0]   diff;
  logic [SEG_SHIFT-1:0]       offset;
  logic signed [ALT_W-1:0]    base;
  logic signed [PROD_W-1:0]   prod;
  logic                       out_valid;

  logic [CNT_W:0]             trial;
  logic                       fits;
  logic [CNT_W:0]             first_rem;
  logic                       first_fits;
  logic [SUM_W-1:0]           sum_mag;
  logic signed [SAMPLE_W-1:0] avg_next;
  logic [SEG_BITS-1:0]        seg;
  logic signed [PROD_W-1:0]   prod_adj;
  logic signed [ALT_W-1:0]    alt_next;
  logic                       out_free;

  always_comb begin
    trial      = {rem[CNT_W-1:0], quo[SUM_W-1]};
    fits       = (trial >= {1'b0, cur.count});
    sum_mag    = cur.sum[SUM_W-1] ? SUM_W'(-cur.sum) : SUM_W'(cur.sum);
    // first step works on the fresh magnitude
    first_rem  = {{CNT_W{1'b0}}, sum_mag[SUM_W-1]};
    first_fits = (first_rem >= {1'b0, cur.count});
    avg_next   = cur.sum[SUM_W-1] ? -$signed(quo[SAMPLE_W-1:0])
                                  : $signed(quo[SAMPLE_W-1:0]);
    seg        = avg[SPAN_LOG2-1:SEG_SHIFT];
    // truncate toward zero on the division by the segment span
    prod_adj = prod + (prod[PROD_W-1] ? PROD_W'((1 << SEG_SHIFT) - 1) : '0);
    alt_next = base + ALT_W'(prod_adj >>> SEG_SHIFT);
    if (avg <= 0) alt_next = ALT_W'(ALT_ZERO_P);
    out_free = !out_valid || pop;
    q_rd     = (state == S_IDLE) && !q_empty;
    empty    = !out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == S_FIN && out_free) out_valid <= 1'b1;
      else if (pop && out_valid) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (!q_empty) state <= S_DIV;
        S_DIV:  if (iter == ITER_W'(SUM_W - 1)) state <= S_LOOK;
        S_LOOK: state <= S_MUL;
        S_MUL:  state <= S_FIN;
        S_FIN:  if (out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cur  <= q_item;
        iter <= '0;
        rem  <= '0;
      end
      S_DIV: begin
        if (iter == '0) begin
          quo <= {sum_mag[SUM_W-2:0], first_fits};
          rem <= first_fits ? first_rem - {1'b0, cur.count} : first_rem;
        end else begin
          quo <= {quo[SUM_W-2:0], fits};
          rem <= fits ? trial - {1'b0, cur.count} : trial;
        end
        iter <= iter + 1'b1;
      end
      S_LOOK: begin
        avg    <= avg_next;
        quo    <= quo;
      end
      S_MUL: begin
        prod <= diff * $signed({1'b0, offset});
      end
      S_FIN: begin
        if (out_free) begin
          signed_pressure   <= cur.sample;
          averaged_pressure <= avg;
          altitude_dm       <= alt_next;
          window_full       <= cur.wrapped;
        end
      end
      default: ;
    endcase
    if (state == S_LOOK) begin
      // table lookup follows from the quotient of this same cycle
      base   <= ALT_TABLE[avg_next[SPAN_LOG2-1:SEG_SHIFT]];
      diff   <= DIFF_W'(ALT_TABLE[{1'b0, avg_next[SPAN_LOG2-1:SEG_SHIFT]} + 1'b1])
              - DIFF_W'(ALT_TABLE[avg_next[SPAN_LOG2-1:SEG_SHIFT]]);
      offset <= avg_next[SEG_SHIFT-1:0];
    end else if (state == S_MUL) begin
      base <= ALT_TABLE[seg];
    end
  end

endmodule

@@ hw/rtl/pressure_average_altitude_top.sv @@
// pressure_average_altitude_top: top level of the averaging altimeter
// depends on pav_pkg, pav_front, pav_queue, pav_back

// Each accepted transaction carries one raw 24-bit two's complement
// pressure word (4096 LSB per hPa) and yields exactly one result: the
// sample read as signed, the moving average over the last WINDOW samples
// (truncated toward zero, divided by the fill count until the ring first
// wraps), the altitude in decimetres from a piecewise-linear table of
// TABLE_SEGMENTS segments, and the window-full flag. The front part updates
// the ring and running sum in the accepting cycle and places the work in a
// two-entry queue; the back part works on one transaction at a time, with
// the bit-serial restoring divider (one quotient bit per cycle over
// the sum width) followed by a table read, one multiply and the result
// write. Results wait in an output register, so the front keeps accepting
// until the queue fills. No clearing pass is needed after reset.

module pressure_average_altitude_top import pav_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [SAMPLE_W-1:0]        raw_sample,
  input  logic                       push,
  output logic                       full,
  output logic signed [SAMPLE_W-1:0] signed_pressure,
  output logic signed [SAMPLE_W-1:0] averaged_pressure,
  output logic signed [ALT_W-1:0]    altitude_dm,
  output logic                       window_full,
  output logic                       empty,
  input  logic                       pop
);

  pav_item_t front_item;
  pav_item_t back_item;
  logic      take;
  logic      q_empty;
  logic      q_rd;

  // an input transaction completes when push meets a queue with room
  assign take = push && !full;

  pav_front u_front (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .raw_sample (raw_sample),
    .item       (front_item)
  );

  // decouples sample bookkeeping from the slow arithmetic
  pav_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (take),
    .wr_item (front_item),
    .full    (full),
    .rd      (q_rd),
    .rd_item (back_item),
    .empty   (q_empty)
  );

  pav_back u_back (
    .clk               (clk),
    .rst               (rst),
    .q_empty           (q_empty),
    .q_item            (back_item),
    .q_rd              (q_rd),
    .signed_pressure   (signed_pressure),
    .averaged_pressure (averaged_pressure),
    .altitude_dm       (altitude_dm),
    .window_full       (window_full),
    .empty             (empty),
    .pop               (pop)
  );

endmodule

@@ bench/tb_pressure_average_altitude_top.sv @@
// tb_pressure_average_altitude_top: self-checking bench for the averaging altimeter
// depends on pav_pkg and pressure_average_altitude_top; predicts each result and
// compares it field by field against each result popped from the block

module tb_pressure_average_altitude_top;
  import pav_pkg::*;

  localparam int NUM_RANDOM = 1780;
  localparam int CALM_ITEMS = 200;   // last stretch with no idling on either side
  localparam int STALL_AT   = 600;   // item count at which the receiver holds off
  localparam int STALL_LEN  = 300;
  localparam int WDOG_LIMIT = 4000;  // cycles with no transaction on either side
  localparam int DRAIN_WAIT = 100;
  localparam int NODE_STEP  = 1 << SEG_SHIFT;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sig_p;
    logic signed [SAMPLE_W-1:0] avg_p;
    logic signed [ALT_W-1:0]    alt;
    logic                       wfull;
  } altimeter_result_t;

  // directed row: raw word, plus a typed result where it is obvious
  typedef struct {
    logic [SAMPLE_W-1:0] raw;
    bit                  typed;
    altimeter_result_t   res;
  } stim_row_t;

  logic                       clk;
  logic                       rst;
  logic [SAMPLE_W-1:0]        raw_sample;
  logic                       push;
  logic                       full;
  logic signed [SAMPLE_W-1:0] signed_pressure;
  logic signed [SAMPLE_W-1:0] averaged_pressure;
  logic signed [ALT_W-1:0]    altitude_dm;
  logic                       window_full;
  logic                       empty;
  logic                       pop;

  pressure_average_altitude_top DUT (
    .clk(clk), .rst(rst), .raw_sample(raw_sample), .push(push), .full(full),
    .signed_pressure(signed_pressure), .averaged_pressure(averaged_pressure),
    .altitude_dm(altitude_dm), .window_full(window_full), .empty(empty), .pop(pop)
  );

  // predictor state: own copy of the ring, running sum and node table
  logic signed [SAMPLE_W-1:0] ring [WINDOW];
  int unsigned                wr_ptr;
  longint                     ring_sum;
  bit                         wrapped;
  longint                     alt_nodes [TABLE_SEGMENTS+1];

  altimeter_result_t pending_results [$];
  int  errors;
  int  n_sent;
  bit  calm;
  int  idle_cycles;

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // truncating base-2 log in q30, by repeated squaring of the mantissa
  function automatic longint q30_log2(logic [63:0] v, int frac_bits);
    int          msb;
    logic [63:0] mant;
    longint      acc;
    if (v == 64'd0) return -64 * Q30_ONE;
    msb = 63;
    while (!v[msb]) msb--;
    mant = (msb >= 30) ? (v >> (msb - 30)) : (v << (30 - msb));
    acc  = longint'(msb - frac_bits) * Q30_ONE;
    for (int k = 0; k < 30; k++) begin
      mant = (mant * mant) >> 30;
      if (mant >= (64'd2 << 30)) begin
        mant = mant >> 1;
        acc  = acc + (64'sd1 << (29 - k));
      end
    end
    return acc;
  endfunction

  // node altitude in decimetres for a pressure in raw lsb
  function automatic longint node_altitude(logic [63:0] p);
    longint      expo, delta;
    logic [63:0] lo, hi, mid, mag;
    expo = ((q30_log2(p, 0) - q30_log2(SEA_LEVEL_LSB, 0)) * 1903) / 10000;
    lo = 64'd1;
    hi = 64'd1 << 31;
    // largest q30 power whose log stays at or below the scaled exponent
    while (hi - lo > 64'd1) begin
      mid = lo + ((hi - lo) >> 1);
      if (q30_log2(mid, 30) <= expo) lo = mid;
      else hi = mid;
    end
    delta = Q30_ONE - longint'(lo);
    mag = (64'(ALT_ZERO_P) * 64'(delta < 0 ? -delta : delta) + (64'd1 << 29)) >> 30;
    return (delta < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint altitude_of_pressure(longint p);
    longint idx, p0, a0, a1;
    if (p <= 0) return ALT_ZERO_P;
    idx = p >>> SEG_SHIFT;
    p0  = idx * NODE_STEP;
    a0  = alt_nodes[idx];
    a1  = alt_nodes[idx+1];
    return a0 + ((a1 - a0) * (p - p0)) / NODE_STEP;
  endfunction

  // one accepted sample: update the ring and work out the averaged result
  function automatic altimeter_result_t average_and_altitude(logic [SAMPLE_W-1:0] raw);
    altimeter_result_t r;
    logic signed [SAMPLE_W-1:0] s;
    longint count, avg;
    s = signed'(raw);
    ring_sum = ring_sum - longint'(ring[wr_ptr]) + longint'(s);
    ring[wr_ptr] = s;
    wr_ptr = (wr_ptr + 1) % WINDOW;
    if (wr_ptr == 0) wrapped = 1'b1;
    count = wrapped ? WINDOW : wr_ptr;
    avg = ring_sum / count;
    r.sig_p = s;
    r.avg_p = SAMPLE_W'(avg);
    r.alt   = ALT_W'(altitude_of_pressure(avg));
    r.wfull = wrapped;
    return r;
  endfunction

  // offer one sample and hold it until the block takes it
  task automatic send_sample(logic [SAMPLE_W-1:0] raw, bit typed, altimeter_result_t typed_res);
    altimeter_result_t r;
    if (!calm && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    push       <= 1'b1;
    raw_sample <= raw;
    @(posedge clk);
    while (full) @(posedge clk);
    r = average_and_altitude(raw);
    pending_results.push_back(typed ? typed_res : r);
    n_sent++;
  endtask

  // mostly realistic pressures around sea level, some full-range noise
  function automatic logic [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(0, 9))
      0, 1:    return SAMPLE_W'($urandom);
      2:       return SAMPLE_W'(-$urandom_range(0, 4096 * 200));
      3:       return SAMPLE_W'($urandom_range(4096 * 1100, 8388607));
      default: return SAMPLE_W'($urandom_range(4096 * 300, 4096 * 1100));
    endcase
  endfunction

  // receiver: random stall bursts, one long hold-off to fill the block
  initial begin
    bit held;
    held = 1'b0;
    pop  = 1'b0;
    @(negedge rst);
    forever begin
      if (!held && n_sent >= STALL_AT) begin
        held = 1'b1;
        pop <= 1'b0;
        repeat (STALL_LEN) @(posedge clk);
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        pop <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // result checker and watchdog, sampling values from before the edge
  always @(posedge clk) begin
    altimeter_result_t e;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("pressure_average_altitude_top: mismatch");
        $finish;
      end
      if (pop && !empty) begin
        if (pending_results.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result transaction");
        end else begin
          e = pending_results.pop_front();
          if (e.sig_p !== signed_pressure || e.avg_p !== averaged_pressure ||
              e.alt !== altitude_dm || e.wfull !== window_full) begin
            errors++;
            if (errors <= 10)
              $display("result differs: exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                       e.sig_p, e.avg_p, e.alt, e.wfull, signed_pressure,
                       averaged_pressure, altitude_dm, window_full);
          end
        end
      end
    end
  end

  // stimulus
  initial begin
    stim_row_t         rows [$];
    stim_row_t         row;
    altimeter_result_t none;
    errors = 0;
    n_sent = 0;
    calm = 1'b0;
    none = '{default: '0};
    rst = 1'b1;
    push = 1'b0;
    raw_sample = '0;
    for (int i = 0; i < WINDOW; i++) ring[i] = '0;
    wr_ptr = 0;
    ring_sum = 0;
    wrapped = 1'b0;
    alt_nodes[0] = ALT_ZERO_P;
    for (int i = 1; i <= TABLE_SEGMENTS; i++) alt_nodes[i] = node_altitude(64'(i * NODE_STEP));

    // after reset: zero saturates, then the most negative word
    rows.push_back('{24'h000000, 1'b1, '{24'sd0, 24'sd0, 20'sd443300, 1'b0}});
    rows.push_back('{24'h800000, 1'b1, '{24'sh800000, -24'sd4194304, 20'sd443300, 1'b0}});
    rows.push_back('{24'h800000, 1'b1, '{24'sh800000, -24'sd5592405, 20'sd443300, 1'b0}});
    // full-scale positive, minus one, tiny positive, sea level, node boundaries
    rows.push_back('{24'h7FFFFF, 1'b0, none});
    rows.push_back('{24'hFFFFFF, 1'b0, none});
    rows.push_back('{24'h000001, 1'b0, none});
    rows.push_back('{24'h7FFFFF, 1'b0, none});
    rows.push_back('{24'h7FFFFF, 1'b0, none});
    for (int i = 0; i < 14; i++)  // enough to wrap the ring at sea level
      rows.push_back('{24'(SEA_LEVEL_LSB + (i - 7) * NODE_STEP), 1'b0, none});
    rows.push_back('{24'h020000, 1'b0, none});
    rows.push_back('{24'h7E0000, 1'b0, none});

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      row = rows[i];
      send_sample(row.raw, row.typed, row.res);
    end
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i >= NUM_RANDOM - CALM_ITEMS) calm = 1'b1;
      send_sample(random_sample(), 1'b0, none);
    end
    push <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("pressure_average_altitude_top: match");
    end else begin
      $display("pressure_average_altitude_top: mismatch");
    end
    $finish;
  end

endmodule
